// File: hw/rtl/mbrfc_pkg.sv
// shared types and constants for the modbus rtu read response checker
package mbrfc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned TEMP_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [BYTE_W-1:0] COUNT_OK  = 8'h02;
    localparam logic [15:0]       RAW_FAULT = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE  = 8'd1;

    localparam logic [BYTE_W-1:0] SLAVE_ADDR_RST = 8'd1;
    localparam logic [BYTE_W-1:0] FUNC_CODE_RST  = 8'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_HDR_BAD      = 3'd1,
        ST_CRC_BAD      = 3'd2,
        ST_COUNT_BAD    = 3'd3,
        ST_SENSOR_FAULT = 3'd4
    } t_status;

    // position of the next byte in the frame
    typedef enum logic [2:0] {
        POS_IDLE    = 3'd0,
        POS_FUNC    = 3'd1,
        POS_COUNT   = 3'd2,
        POS_DATA_HI = 3'd3,
        POS_DATA_LO = 3'd4,
        POS_CRC_LO  = 3'd5,
        POS_CRC_HI  = 3'd6
    } t_byte_pos;

endpackage

// File: hw/rtl/mbrfc_crc_step.sv
// one byte of crc-16 (reflected poly 0xa001), eight bit steps unrolled
module mbrfc_crc_step (
    input  logic [mbrfc_pkg::CRC_W-1:0]  i_crc,
    input  logic [mbrfc_pkg::BYTE_W-1:0] i_byte,
    output logic [mbrfc_pkg::CRC_W-1:0]  o_crc
);

    always_comb begin
        logic [mbrfc_pkg::CRC_W-1:0] c;
        c = i_crc ^ {{(mbrfc_pkg::CRC_W - mbrfc_pkg::BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < mbrfc_pkg::BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mbrfc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// File: hw/rtl/modbus_rtu_reading_frame_checker.sv
// top level: checks a 7-byte modbus rtu read response and decodes the reading
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+------------------------------
//  in      | in        | i_in_valid / o_in_ready        | i_rx_byte, i_frame_start
//  out     | out       | o_out_valid / i_out_ready      | o_status, o_temperature_tenths
//  cfg     | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one word per cycle while o_in_ready is high; each byte updates the frame state,
// and header and data bytes the crc, in the cycle taken; the seventh byte loads the
// result register. the result appears the cycle after the seventh byte; a held result
// stalls input only when the downstream side is not ready in that same cycle.
// synchronous active-low reset returns to idle with slave address 1, function 4.
// the configuration port is always ready.
module modbus_rtu_reading_frame_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [mbrfc_pkg::BYTE_W-1:0]           i_rx_byte,
    input  logic                                   i_frame_start,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [mbrfc_pkg::STATUS_W-1:0]         o_status,
    output logic signed [mbrfc_pkg::TEMP_W-1:0]    o_temperature_tenths,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mbrfc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mbrfc_pkg::BYTE_W-1:0]           i_cfg_data
);

    localparam int unsigned TEMP_W_M1 = mbrfc_pkg::TEMP_W - 1;

    logic [mbrfc_pkg::BYTE_W-1:0] r_slave_addr;
    logic [mbrfc_pkg::BYTE_W-1:0] r_func_code;

    mbrfc_pkg::t_byte_pos r_pos, n_pos;
    logic [mbrfc_pkg::CRC_W-1:0]  r_crc, n_crc;
    logic                         r_hdr_ok, n_hdr_ok;
    logic [mbrfc_pkg::BYTE_W-1:0] r_count, n_count;
    logic [mbrfc_pkg::BYTE_W-1:0] r_data_hi, n_data_hi;
    logic [mbrfc_pkg::BYTE_W-1:0] r_data_lo, n_data_lo;
    logic [mbrfc_pkg::BYTE_W-1:0] r_crc_lo, n_crc_lo;

    logic                                r_out_valid, n_out_valid;
    mbrfc_pkg::t_status                  r_status, n_status;
    logic signed [mbrfc_pkg::TEMP_W-1:0] r_temp, n_temp;

    logic                         in_fire;
    logic                         result_now;
    logic [mbrfc_pkg::CRC_W-1:0]  crc_base;
    logic [mbrfc_pkg::CRC_W-1:0]  crc_next;
    logic [15:0]                  raw;
    logic [TEMP_W_M1:0]           mag;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_temperature_tenths = r_temp;

    // a frame start always reseeds the crc
    assign crc_base = i_frame_start ? mbrfc_pkg::CRC_INIT : r_crc;

    mbrfc_crc_step u_crc (
        .i_crc  (crc_base),
        .i_byte (i_rx_byte),
        .o_crc  (crc_next)
    );

    // next frame state
    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_hdr_ok  = r_hdr_ok;
        n_count   = r_count;
        n_data_hi = r_data_hi;
        n_data_lo = r_data_lo;
        n_crc_lo  = r_crc_lo;
        if (in_fire) begin
            if (i_frame_start) begin
                n_crc    = crc_next;
                n_hdr_ok = (i_rx_byte == r_slave_addr);
                n_pos    = mbrfc_pkg::POS_FUNC;
            end else begin
                case (r_pos)
                    mbrfc_pkg::POS_FUNC: begin
                        n_crc    = crc_next;
                        n_hdr_ok = r_hdr_ok && (i_rx_byte == r_func_code);
                        n_pos    = mbrfc_pkg::POS_COUNT;
                    end
                    mbrfc_pkg::POS_COUNT: begin
                        n_crc   = crc_next;
                        n_count = i_rx_byte;
                        n_pos   = mbrfc_pkg::POS_DATA_HI;
                    end
                    mbrfc_pkg::POS_DATA_HI: begin
                        n_crc     = crc_next;
                        n_data_hi = i_rx_byte;
                        n_pos     = mbrfc_pkg::POS_DATA_LO;
                    end
                    mbrfc_pkg::POS_DATA_LO: begin
                        n_crc     = crc_next;
                        n_data_lo = i_rx_byte;
                        n_pos     = mbrfc_pkg::POS_CRC_LO;
                    end
                    mbrfc_pkg::POS_CRC_LO: begin
                        n_crc_lo = i_rx_byte;
                        n_pos    = mbrfc_pkg::POS_CRC_HI;
                    end
                    default: begin
                        n_pos = mbrfc_pkg::POS_IDLE;
                    end
                endcase
            end
        end
    end

    assign raw = {r_data_hi, r_data_lo};
    assign mag = {1'b0, raw[14:0]};

    // result on the crc high byte
    always_comb begin
        result_now = in_fire && !i_frame_start && (r_pos == mbrfc_pkg::POS_CRC_HI);
        n_status   = r_status;
        n_temp     = r_temp;
        if (result_now) begin
            n_temp = '0;
            if (!r_hdr_ok) begin
                n_status = mbrfc_pkg::ST_HDR_BAD;
            end else if (r_crc_lo != r_crc[7:0] || i_rx_byte != r_crc[15:8]) begin
                n_status = mbrfc_pkg::ST_CRC_BAD;
            end else if (r_count != mbrfc_pkg::COUNT_OK) begin
                n_status = mbrfc_pkg::ST_COUNT_BAD;
            end else if (raw == mbrfc_pkg::RAW_FAULT) begin
                n_status = mbrfc_pkg::ST_SENSOR_FAULT;
            end else begin
                n_status = mbrfc_pkg::ST_OK;
                // sign-magnitude to two's complement, negative zero gives zero
                n_temp   = raw[15] ? -$signed(mag) : $signed(mag);
            end
        end
        if (result_now) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= mbrfc_pkg::SLAVE_ADDR_RST;
            r_func_code  <= mbrfc_pkg::FUNC_CODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbrfc_pkg::CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data;
                mbrfc_pkg::CFG_FUNC_CODE:  r_func_code  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= mbrfc_pkg::POS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc     <= n_crc;
        r_hdr_ok  <= n_hdr_ok;
        r_count   <= n_count;
        r_data_hi <= n_data_hi;
        r_data_lo <= n_data_lo;
        r_crc_lo  <= n_crc_lo;
        r_status  <= n_status;
        r_temp    <= n_temp;
    end

endmodule
